>>> src/particle_emitter_update_top_defines.svh
// assertion macros for the particle emitter update block
// used by the checker module, no other dependencies
`ifndef PARTICLE_EMITTER_UPDATE_TOP_DEFINES_SVH
`define PARTICLE_EMITTER_UPDATE_TOP_DEFINES_SVH

// implication in the same cycle, reset disables the check
`define PE_ASSERT_SAME(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("particle emitter check failed");

// implication in the next cycle, reset disables the check
`define PE_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("particle emitter check failed");

`endif

>>> src/pe_pkg.sv
// shared types, constants and functions of the particle emitter update block
// no dependencies
`timescale 1ns / 1ps
package pe_pkg;

  localparam int PE_CAPACITY = 64;
  localparam int LIFE_W      = 25;
  localparam int POS_W       = 32;
  localparam int MEM_W       = LIFE_W + 3 * POS_W;

  // func codes of an input transaction
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_RESET   = 2'd1;
  localparam logic [1:0] FUNC_DESTROY = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_BURST    = 3'd0;
  localparam logic [2:0] REG_PERIOD   = 3'd1;
  localparam logic [2:0] REG_LIFETIME = 3'd2;
  localparam logic [2:0] REG_VEL_X    = 3'd3;
  localparam logic [2:0] REG_VEL_Y    = 3'd4;
  localparam logic [2:0] REG_VEL_Z    = 3'd5;
  localparam logic [2:0] REG_LOOPING  = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic        has_particle;
    logic [5:0]  slot;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [23:0] life_left;
    logic        finished;
    logic        last;
  } result_t;

  // subtract a time step, saturating at -2^24
  function automatic logic [LIFE_W-1:0] sat_sub(input logic [LIFE_W-1:0] v,
                                                input logic [15:0] dt);
    logic signed [LIFE_W:0] r;
    r = $signed({v[LIFE_W-1], v}) - $signed({{(LIFE_W-16+1){1'b0}}, dt});
    if (r < -(26'sd1 <<< 24)) begin
      sat_sub = {1'b1, {(LIFE_W-1){1'b0}}};
    end else begin
      sat_sub = r[LIFE_W-1:0];
    end
  endfunction

endpackage

>>> src/pe_in_if.sv
// input channel interface: func, time step and origin
// depends on nothing
`timescale 1ns / 1ps
interface pe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] delta_time;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  modport source (output valid, func, delta_time, origin_x, origin_y, origin_z,
                  input ready);
  modport sink (input valid, func, delta_time, origin_x, origin_y, origin_z,
                output ready);
endinterface

>>> src/pe_out_if.sv
// result channel interface: one particle report per transaction
// depends on nothing
`timescale 1ns / 1ps
interface pe_out_if;
  logic        valid;
  logic        ready;
  logic        has_particle;
  logic [5:0]  slot;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [23:0] life_left;
  logic        finished;
  logic        last;
  modport source (output valid, has_particle, slot, pos_x, pos_y, pos_z,
                  life_left, finished, last, input ready);
  modport sink (input valid, has_particle, slot, pos_x, pos_y, pos_z,
                life_left, finished, last, output ready);
endinterface

>>> src/pe_cfg_if.sv
// configuration write channel interface: register index and data
// depends on nothing
`timescale 1ns / 1ps
interface pe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/particle_emitter_update_top.sv
// particle emitter update block: top level with sequencer and slot walk
// depends on pe_pkg, pe_in_if, pe_out_if, pe_cfg_if and pe_ram
//
// channel  | dir | transaction
// in_ch    | in  | one command: tick, reset emitter or destroy
// out_ch   | out | one particle report, last set on the final one
// cfg_ch   | in  | one register write, always ready
//
// an item goes through emitter bookkeeping and velocity products (one
// shared 32x17 multiplier), then one slot per cycle over CAPACITY slots of
// the particle ram while the result channel does not stall, then a flush.
// reset is synchronous and clears live bits and emitter state; the ram needs
// no clearing pass. a stalled result channel holds the slot walk in place.
`timescale 1ns / 1ps
module particle_emitter_update_top #(
  parameter int CAPACITY = pe_pkg::PE_CAPACITY
) (
  input logic    clk,
  input logic    rst_n,
  pe_in_if.sink  in_ch,
  pe_out_if.source out_ch,
  pe_cfg_if.sink cfg_ch
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = pe_pkg::LIFE_W;

  // configuration registers
  logic [6:0]  burst_r;
  logic [23:0] period_r;
  logic [23:0] lifetime_r;
  logic [31:0] vel_x_r, vel_y_r, vel_z_r;
  logic        looping_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r    <= 7'd1;
      period_r   <= 24'd65536;
      lifetime_r <= 24'd65536;
      vel_x_r    <= '0;
      vel_y_r    <= '0;
      vel_z_r    <= '0;
      looping_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pe_pkg::REG_BURST:    burst_r    <= cfg_ch.data[6:0];
        pe_pkg::REG_PERIOD:   period_r   <= cfg_ch.data[23:0];
        pe_pkg::REG_LIFETIME: lifetime_r <= cfg_ch.data[23:0];
        pe_pkg::REG_VEL_X:    vel_x_r    <= cfg_ch.data;
        pe_pkg::REG_VEL_Y:    vel_y_r    <= cfg_ch.data;
        pe_pkg::REG_VEL_Z:    vel_z_r    <= cfg_ch.data;
        pe_pkg::REG_LOOPING:  looping_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // control and emitter state
  pe_pkg::state_t state_r, state_nxt;
  logic [1:0]    mul_cnt_r;
  logic [IW-1:0] p_idx_r;
  logic          live_r [CAPACITY];
  logic [LW-1:0] emit_life_r, spawn_cd_r;
  logic          finished_r;
  logic          spawn_r;
  logic [6:0]    left_r;
  logic          hold_v_r, out_v_r;
  pe_pkg::result_t hold_r, out_r;

  // latched command
  logic [1:0]  func_r;
  logic [15:0] dt_r;
  logic [31:0] org_x_r, org_y_r, org_z_r;
  logic [31:0] dx_r, dy_r, dz_r;

  logic accept;
  assign in_ch.ready = (state_r == pe_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_ch.func;
      dt_r    <= in_ch.delta_time;
      org_x_r <= in_ch.origin_x;
      org_y_r <= in_ch.origin_y;
      org_z_r <= in_ch.origin_z;
    end
  end

  // shared velocity multiplier, one axis per cycle
  logic [31:0]        vel_sel;
  logic signed [48:0] prod;
  always_comb begin
    unique case (mul_cnt_r)
      2'd0:    vel_sel = vel_x_r;
      2'd1:    vel_sel = vel_y_r;
      default: vel_sel = vel_z_r;
    endcase
  end
  assign prod = $signed(vel_sel) * $signed({1'b0, dt_r});

  always_ff @(posedge clk) begin
    if (state_r == pe_pkg::ST_MUL) begin
      unique case (mul_cnt_r)
        2'd0:    dx_r <= prod[47:16];
        2'd1:    dy_r <= prod[47:16];
        default: dz_r <= prod[47:16];
      endcase
    end
  end

  // particle ram: life, x, y, z per slot
  logic                    ram_we;
  logic [IW-1:0]           ram_raddr;
  logic [pe_pkg::MEM_W-1:0] ram_wdata, ram_rdata;

  pe_ram #(.WIDTH(pe_pkg::MEM_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // per slot update of the walk
  logic          do_tick, slot_live, spawn_here, live_after, res_v;
  logic          out_free, adv, p_end;
  logic [LW-1:0] new_life;
  logic [31:0]   new_x, new_y, new_z;
  pe_pkg::result_t res;

  assign do_tick  = (func_r == pe_pkg::FUNC_TICK);
  assign slot_live = live_r[p_idx_r];
  assign spawn_here = do_tick && !slot_live && spawn_r && (left_r != 7'd0);
  assign p_end    = (p_idx_r == IW'(CAPACITY - 1));

  always_comb begin
    new_life = ram_rdata[pe_pkg::MEM_W-1 -: LW];
    new_x    = ram_rdata[95:64];
    new_y    = ram_rdata[63:32];
    new_z    = ram_rdata[31:0];
    live_after = slot_live;
    if (do_tick) begin
      if (slot_live) begin
        new_life = pe_pkg::sat_sub(ram_rdata[pe_pkg::MEM_W-1 -: LW], dt_r);
        new_x    = ram_rdata[95:64] + dx_r;
        new_y    = ram_rdata[63:32] + dy_r;
        new_z    = ram_rdata[31:0] + dz_r;
      end else begin
        new_life = pe_pkg::sat_sub({1'b0, lifetime_r}, dt_r);
        new_x    = org_x_r + dx_r;
        new_y    = org_y_r + dy_r;
        new_z    = org_z_r + dz_r;
      end
      live_after = (slot_live || spawn_here) && !new_life[LW-1];
    end
  end

  assign ram_wdata = {new_life, new_x, new_y, new_z};
  assign res_v    = (state_r == pe_pkg::ST_WALK) && live_after;
  assign out_free = !out_v_r || out_ch.ready;
  assign adv      = (state_r == pe_pkg::ST_WALK) && (!res_v || !hold_v_r || out_free);
  assign ram_we   = adv && do_tick && (slot_live || spawn_here);

  always_comb begin
    res.has_particle = 1'b1;
    res.slot         = 6'(p_idx_r);
    res.pos_x        = new_x;
    res.pos_y        = new_y;
    res.pos_z        = new_z;
    res.life_left    = new_life[23:0];
    res.finished     = finished_r;
    res.last         = 1'b0;
  end

  // final report of a command: the held one, or an empty one
  pe_pkg::result_t flush_res;
  always_comb begin
    flush_res          = '0;
    flush_res.finished = finished_r;
    if (hold_v_r) begin
      flush_res = hold_r;
    end
    flush_res.last = 1'b1;
  end

  // read address: slot zero at the end of the products, next slot on advance, else the same slot again
  always_comb begin
    ram_raddr = p_idx_r;
    if (state_r == pe_pkg::ST_MUL && mul_cnt_r == 2'd2) begin
      ram_raddr = '0;
    end else if (adv) begin
      ram_raddr = p_idx_r + IW'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pe_pkg::ST_IDLE:  if (accept) state_nxt = pe_pkg::ST_MUL;
      pe_pkg::ST_MUL:   if (mul_cnt_r == 2'd2) state_nxt = pe_pkg::ST_WALK;
      pe_pkg::ST_WALK:  if (adv && p_end) state_nxt = pe_pkg::ST_FLUSH;
      pe_pkg::ST_FLUSH: if (out_free) state_nxt = pe_pkg::ST_IDLE;
      default:          state_nxt = pe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer counters, emitter bookkeeping and live bits
  logic [LW-1:0] el_dec, sc_dec;
  assign el_dec = pe_pkg::sat_sub(emit_life_r, dt_r);
  assign sc_dec = pe_pkg::sat_sub(spawn_cd_r, dt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r   <= '0;
      p_idx_r     <= '0;
      emit_life_r <= LW'(65536);
      spawn_cd_r  <= '0;
      finished_r  <= 1'b0;
      spawn_r     <= 1'b0;
      left_r      <= '0;
      for (int i = 0; i < CAPACITY; i++) live_r[i] <= 1'b0;
    end else begin
      if (accept) begin
        mul_cnt_r <= '0;
      end
      if (state_r == pe_pkg::ST_MUL) begin
        mul_cnt_r <= mul_cnt_r + 2'd1;
        p_idx_r   <= '0;
        if (mul_cnt_r == 2'd0) begin
          left_r  <= burst_r;
          spawn_r <= 1'b0;
          unique case (func_r)
            pe_pkg::FUNC_TICK: begin
              emit_life_r <= el_dec;
              if (el_dec[LW-1] && !looping_r) finished_r <= 1'b1;
              if (sc_dec[LW-1] || sc_dec == '0) begin
                spawn_r    <= 1'b1;
                spawn_cd_r <= {1'b0, period_r};
              end else begin
                spawn_cd_r <= sc_dec;
              end
            end
            pe_pkg::FUNC_RESET: begin
              emit_life_r <= {1'b0, lifetime_r};
              for (int i = 0; i < CAPACITY; i++) live_r[i] <= 1'b0;
            end
            pe_pkg::FUNC_DESTROY: begin
              finished_r <= 1'b1;
              for (int i = 0; i < CAPACITY; i++) live_r[i] <= 1'b0;
            end
            default: ;
          endcase
        end
      end
      if (adv) begin
        live_r[p_idx_r] <= live_after;
        if (spawn_here) left_r <= left_r - 7'd1;
        if (!p_end) p_idx_r <= p_idx_r + IW'(1);
      end
    end
  end

  // one result held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (adv && res_v) begin
        hold_v_r <= 1'b1;
        hold_r   <= res;
        if (hold_v_r) begin
          out_v_r <= 1'b1;
          out_r   <= hold_r;
        end else if (out_ch.ready) begin
          out_v_r <= 1'b0;
        end
      end else if (state_r == pe_pkg::ST_FLUSH && out_free) begin
        out_v_r  <= 1'b1;
        hold_v_r <= 1'b0;
        out_r    <= flush_res;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.has_particle = out_r.has_particle;
  assign out_ch.slot         = out_r.slot;
  assign out_ch.pos_x        = out_r.pos_x;
  assign out_ch.pos_y        = out_r.pos_y;
  assign out_ch.pos_z        = out_r.pos_z;
  assign out_ch.life_left    = out_r.life_left;
  assign out_ch.finished     = out_r.finished;
  assign out_ch.last         = out_r.last;

endmodule

>>> src/pe_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module pe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/pe_checker.sv
// port level checker for the particle emitter update block, with its bind
// depends on particle_emitter_update_top_defines.svh and the top level
`timescale 1ns / 1ps
`include "particle_emitter_update_top_defines.svh"
module pe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_has_particle,
  input logic [5:0]  out_slot,
  input logic [23:0] out_life_left,
  input logic        out_last
);
  // a result waiting on the sink stays offered
  `PE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // an accepted command keeps the channel not ready in the next cycle
  `PE_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  // an empty report is always the final one of its command
  `PE_ASSERT_SAME(a_empty_last, clk, rst_n, out_valid && !out_has_particle,
                  out_last)
  // an empty report carries slot zero and no life
  `PE_ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && !out_has_particle,
                  out_slot == 6'd0 && out_life_left == 24'd0)
endmodule

bind particle_emitter_update_top pe_checker u_pe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_has_particle (out_ch.has_particle),
  .out_slot         (out_ch.slot),
  .out_life_left    (out_ch.life_left),
  .out_last         (out_ch.last)
);

>>> sim/tb_particle_emitter_update_top.sv
// self-checking testbench for the particle emitter update block
// depends on pe_pkg, pe_in_if, pe_out_if, pe_cfg_if and particle_emitter_update_top
`timescale 1ns / 1ps
module tb_particle_emitter_update_top;

  localparam int  N_SLOTS     = pe_pkg::PE_CAPACITY;
  localparam int  DRAIN_WAIT  = N_SLOTS + 12;
  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam int  N_PHASES    = 8;
  localparam int  PHASE_ITEMS = 53;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic signed [25:0] LIFE_FLOOR = -(26'sd1 <<< 24);

  typedef struct {
    logic [1:0]  func;
    logic [15:0] dt;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oz;
    bit          typed;
    pe_pkg::result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  pe_in_if  in_ch ();
  pe_out_if out_ch ();
  pe_cfg_if cfg_ch ();

  particle_emitter_update_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // emitter state mirror
  logic [6:0]         m_burst;
  logic [23:0]        m_period;
  logic [23:0]        m_part_life;
  logic [31:0]        m_vel_x, m_vel_y, m_vel_z;
  logic               m_looping;
  bit                 m_live [N_SLOTS];
  logic signed [24:0] m_life [N_SLOTS];
  logic [31:0]        m_px [N_SLOTS];
  logic [31:0]        m_py [N_SLOTS];
  logic [31:0]        m_pz [N_SLOTS];
  logic signed [24:0] m_emitter_life;
  logic signed [24:0] m_spawn_cnt;
  bit                 m_finished;

  pe_pkg::result_t pending_reports[$];
  int        err_count;
  int        cycle_count;
  int        items_sent;
  int        reports_seen;
  int        in_idle_pct;
  int        out_stall_pct;
  dir_row_t  dir_rows[9];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [24:0] life_step(logic signed [24:0] v, logic [15:0] dt);
    logic signed [25:0] r;
    r = $signed({v[24], v}) - $signed({10'd0, dt});
    if (r < LIFE_FLOOR) r = LIFE_FLOOR;
    return r[24:0];
  endfunction

  function automatic logic [31:0] pos_step(logic [31:0] vel, logic [15:0] dt);
    logic signed [63:0] p;
    p = $signed({{32{vel[31]}}, vel}) * $signed({48'd0, dt});
    return p[47:16];
  endfunction

  // predict the particle reports caused by one command
  task automatic predict_reports(input logic [1:0] func, input logic [15:0] dt,
                                 input logic [31:0] ox, oy, oz,
                                 ref pe_pkg::result_t res[$]);
    int left;
    logic [31:0] dx, dy, dz;
    pe_pkg::result_t r;
    res.delete();
    if (func == pe_pkg::FUNC_TICK) begin
      m_emitter_life = life_step(m_emitter_life, dt);
      m_spawn_cnt = life_step(m_spawn_cnt, dt);
      if (m_emitter_life < 0 && !m_looping) m_finished = 1'b1;
      if (m_spawn_cnt <= 0) begin
        left = int'(m_burst);
        for (int i = 0; i < N_SLOTS && left > 0; i++) begin
          if (!m_live[i]) begin
            m_live[i] = 1'b1;
            m_life[i] = $signed({1'b0, m_part_life});
            m_px[i] = ox;
            m_py[i] = oy;
            m_pz[i] = oz;
            left--;
          end
        end
        m_spawn_cnt = $signed({1'b0, m_period});
      end
      dx = pos_step(m_vel_x, dt);
      dy = pos_step(m_vel_y, dt);
      dz = pos_step(m_vel_z, dt);
      for (int i = 0; i < N_SLOTS; i++) begin
        if (m_live[i]) begin
          m_life[i] = life_step(m_life[i], dt);
          m_px[i] += dx;
          m_py[i] += dy;
          m_pz[i] += dz;
          if (m_life[i] < 0) m_live[i] = 1'b0;
        end
      end
    end else if (func == pe_pkg::FUNC_RESET) begin
      foreach (m_live[i]) m_live[i] = 1'b0;
      m_emitter_life = $signed({1'b0, m_part_life});
    end else if (func == pe_pkg::FUNC_DESTROY) begin
      m_finished = 1'b1;
      foreach (m_live[i]) m_live[i] = 1'b0;
    end
    for (int i = 0; i < N_SLOTS; i++) begin
      if (m_live[i]) begin
        r = '{1'b1, 6'(i), m_px[i], m_py[i], m_pz[i], m_life[i][23:0], m_finished, 1'b0};
        res = {res, r};
      end
    end
    // empty store still gives one report
    if (res.size() == 0) begin
      r = '{1'b0, 6'd0, 32'd0, 32'd0, 32'd0, 24'd0, m_finished, 1'b0};
      res = {res, r};
    end
    res[res.size()-1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    err_count++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, exp);
  endtask

  // result channel: random stalls, compare against oldest expectation
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready = 1'b0;
    else out_ch.ready = ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    pe_pkg::result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(out_ch.slot), 32'd0);
      end else begin
        e = pending_reports.pop_front();
        if (out_ch.has_particle !== e.has_particle)
          report_mismatch("has_particle", 32'(out_ch.has_particle), 32'(e.has_particle));
        if (out_ch.slot !== e.slot)
          report_mismatch("slot", 32'(out_ch.slot), 32'(e.slot));
        if (out_ch.pos_x !== e.pos_x) report_mismatch("pos_x", out_ch.pos_x, e.pos_x);
        if (out_ch.pos_y !== e.pos_y) report_mismatch("pos_y", out_ch.pos_y, e.pos_y);
        if (out_ch.pos_z !== e.pos_z) report_mismatch("pos_z", out_ch.pos_z, e.pos_z);
        if (out_ch.life_left !== e.life_left)
          report_mismatch("life_left", 32'(out_ch.life_left), 32'(e.life_left));
        if (out_ch.finished !== e.finished)
          report_mismatch("finished", 32'(out_ch.finished), 32'(e.finished));
        if (out_ch.last !== e.last)
          report_mismatch("last", 32'(out_ch.last), 32'(e.last));
      end
    end
  end

  // drive one command transaction, valid is held across back-to-back commands
  task automatic send_cmd(input logic [1:0] func, input logic [15:0] dt,
                          input logic [31:0] ox, oy, oz, input bit typed,
                          input pe_pkg::result_t typed_res);
    pe_pkg::result_t res[$];
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func = func;
    in_ch.delta_time = dt;
    in_ch.origin_x = ox;
    in_ch.origin_y = oy;
    in_ch.origin_z = oz;
    do @(posedge clk); while (!in_ch.ready);
    predict_reports(func, dt, ox, oy, oz, res);
    if (typed) pending_reports = {pending_reports, typed_res};
    else pending_reports = {pending_reports, res};
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      pe_pkg::REG_BURST:    m_burst = data[6:0];
      pe_pkg::REG_PERIOD:   m_period = data[23:0];
      pe_pkg::REG_LIFETIME: m_part_life = data[23:0];
      pe_pkg::REG_VEL_X:    m_vel_x = data;
      pe_pkg::REG_VEL_Y:    m_vel_y = data;
      pe_pkg::REG_VEL_Z:    m_vel_z = data;
      pe_pkg::REG_LOOPING:  m_looping = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // main sequence
  initial begin
    logic [1:0]  func;
    logic [15:0] dt;
    int          sel;
    err_count = 0;
    cycle_count = 0;
    items_sent = 0;
    reports_seen = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = pe_pkg::FUNC_TICK;
    in_ch.delta_time = '0;
    in_ch.origin_x = '0;
    in_ch.origin_y = '0;
    in_ch.origin_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = pe_pkg::REG_BURST;
    cfg_ch.data = '0;
    m_burst = 7'd1;
    m_period = 24'd65536;
    m_part_life = 24'd65536;
    m_vel_x = '0;
    m_vel_y = '0;
    m_vel_z = '0;
    m_looping = 1'b0;
    foreach (m_live[i]) m_live[i] = 1'b0;
    m_emitter_life = 25'sd65536;
    m_spawn_cnt = '0;
    m_finished = 1'b0;

    // directed commands at reset settings; typed rows carry their own expected report
    dir_rows = '{
      '{pe_pkg::FUNC_TICK, 16'd0, 32'd1, 32'd2, 32'd3, 1'b1,
        '{1'b1, 6'd0, 32'd1, 32'd2, 32'd3, 24'h010000, 1'b0, 1'b1}},
      '{pe_pkg::FUNC_TICK, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0},
      '{pe_pkg::FUNC_TICK, 16'hffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
      '{FUNC_SPARE, 16'h1234, 32'd5, 32'd6, 32'd7, 1'b0, '0},
      '{pe_pkg::FUNC_DESTROY, 16'h00ff, 32'd9, 32'd9, 32'd9, 1'b1,
        '{1'b0, 6'd0, 32'd0, 32'd0, 32'd0, 24'd0, 1'b1, 1'b1}},
      '{pe_pkg::FUNC_RESET, 16'hff00, 32'd9, 32'd9, 32'd9, 1'b1,
        '{1'b0, 6'd0, 32'd0, 32'd0, 32'd0, 24'd0, 1'b1, 1'b1}},
      '{pe_pkg::FUNC_TICK, 16'd0, 32'hffff_ffff, 32'h0, 32'h5555_aaaa, 1'b0, '0},
      '{pe_pkg::FUNC_TICK, 16'hffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, '0},
      '{FUNC_SPARE, 16'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].func, dir_rows[i].dt, dir_rows[i].ox, dir_rows[i].oy,
               dir_rows[i].oz, dir_rows[i].typed, dir_rows[i].res);

    // random phases, each with its own settings and idle pattern
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 68; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 68; end
        default: begin in_idle_pct = 24; out_stall_pct = 24; end
      endcase
      case (p)
        0: begin
          write_reg(pe_pkg::REG_BURST, 32'd64);
          write_reg(pe_pkg::REG_PERIOD, 32'd0);
          write_reg(pe_pkg::REG_LIFETIME, 32'h0020_0000);
          write_reg(pe_pkg::REG_VEL_X, 32'h7fff_ffff);
          write_reg(pe_pkg::REG_VEL_Y, 32'h8000_0000);
          write_reg(pe_pkg::REG_VEL_Z, 32'hffff_ffff);
          write_reg(pe_pkg::REG_LOOPING, 32'd0);
        end
        1: begin
          write_reg(pe_pkg::REG_BURST, 32'd0);
          write_reg(pe_pkg::REG_PERIOD, 32'h00ff_ffff);
          write_reg(pe_pkg::REG_LIFETIME, 32'd0);
          write_reg(pe_pkg::REG_VEL_X, 32'd0);
          write_reg(pe_pkg::REG_LOOPING, 32'd1);
        end
        2: begin
          write_reg(pe_pkg::REG_BURST, 32'd3);
          write_reg(pe_pkg::REG_PERIOD, 32'h8000);
          write_reg(pe_pkg::REG_LIFETIME, 32'h0002_0000);
          write_reg(pe_pkg::REG_VEL_X, $urandom);
          write_reg(pe_pkg::REG_VEL_Y, $urandom);
          write_reg(pe_pkg::REG_VEL_Z, $urandom);
        end
        3: begin
          write_reg(pe_pkg::REG_BURST, 32'd5);
          write_reg(pe_pkg::REG_PERIOD, 32'd0);
          write_reg(pe_pkg::REG_LIFETIME, 32'h00ff_ffff);
          write_reg(pe_pkg::REG_LOOPING, 32'd0);
        end
        default: begin
          write_reg(pe_pkg::REG_BURST, $urandom_range(64));
          write_reg(pe_pkg::REG_PERIOD, $urandom_range(32'h0004_0000));
          write_reg(pe_pkg::REG_LIFETIME, $urandom_range(32'h0008_0000));
          write_reg(pe_pkg::REG_VEL_X, pick_word());
          write_reg(pe_pkg::REG_VEL_Y, pick_word());
          write_reg(pe_pkg::REG_VEL_Z, pick_word());
          write_reg(pe_pkg::REG_LOOPING, $urandom_range(1));
        end
      endcase
      // mostly ticks; destroy only late since finished then sticks
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(99);
        if (sel < 82) func = pe_pkg::FUNC_TICK;
        else if (sel < 90) func = pe_pkg::FUNC_RESET;
        else if (sel < 95 && p >= 5) func = pe_pkg::FUNC_DESTROY;
        else if (sel < 95) func = pe_pkg::FUNC_TICK;
        else func = FUNC_SPARE;
        dt = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4000));
        send_cmd(func, dt, pick_word(), pick_word(), pick_word(), 1'b0, '0);
      end
    end

    drain();
    $display("covered %0d commands and %0d particle reports over %0d setting phases",
             items_sent, reports_seen, N_PHASES + 1);
    $display("with full-store drops, emitter expiry, looping and idle/stall mixes");
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
